// ===== design/fmpl_pkg.sv =====
// ----------------------------------------------------------------------------
// fmpl_pkg
// Shared widths, codes and types of the first-minimum parabolic locator.
// ----------------------------------------------------------------------------
package fmpl_pkg;

   localparam int VALUE_W   = 16;
   localparam int FRAC_W    = 14;
   localparam int CFG_W     = 24;
   localparam int OFF_W     = 17;
   localparam int NUM_W     = 31;
   localparam int DVS_W     = 18;
   localparam int DEN_W     = 19;
   localparam int MIN_BIN_W = 11;
   localparam int POS_W     = 32;
   localparam int STATUS_W  = 2;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [VALUE_W-1:0] ONE_Q14    = 16'd16384;
   localparam logic [FRAC_W-1:0]  ROUND_HALF = 14'd8192;
   localparam logic [OFF_W-1:0]   OFF_MAX    = 17'h0FFFF;
   localparam logic [OFF_W-1:0]   OFF_MIN    = 17'h10000;
   localparam logic [CFG_W-1:0]   BIN_WIDTH_RST = 24'd83046;

   localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FLAT  = 2'd2;

   localparam logic CSR_FIRST_BIN_CENTER = 1'b0;
   localparam logic CSR_BIN_WIDTH        = 1'b1;

   typedef struct packed {
      logic [CFG_W-1:0] first_bin_center;
      logic [CFG_W-1:0] bin_width;
   } cfg_type;

endpackage

// ===== design/fmpl_csr.sv =====
// ----------------------------------------------------------------------------
// fmpl_csr
// APB-style register file: bin center origin and bin width.
// ----------------------------------------------------------------------------
module fmpl_csr import fmpl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   logic    reg_sel;
   logic    wr_en;

   assign reg_sel = paddr[2];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_bin_center <= '0;
         cfg_ff.bin_width        <= BIN_WIDTH_RST;
      end else if (wr_en) begin
         unique case (reg_sel)
            CSR_FIRST_BIN_CENTER: cfg_ff.first_bin_center <= pwdata[CFG_W-1:0];
            CSR_BIN_WIDTH:        cfg_ff.bin_width        <= pwdata[CFG_W-1:0];
            default:              cfg_ff <= cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         CSR_FIRST_BIN_CENTER: prdata = {{(CSR_DATA_W-CFG_W){1'b0}}, cfg_ff.first_bin_center};
         CSR_BIN_WIDTH:        prdata = {{(CSR_DATA_W-CFG_W){1'b0}}, cfg_ff.bin_width};
         default:              prdata = '0;
      endcase
   end

endmodule

// ===== design/fmpl_div.sv =====
// ----------------------------------------------------------------------------
// fmpl_div
// Bit-serial restoring divider for the vertex offset, one quotient bit per
// cycle, with saturation of the signed result to four bins.
// ----------------------------------------------------------------------------
module fmpl_div import fmpl_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DVS_W-1:0] dvs,
   input  logic             neg,
   output logic             done,
   output logic [OFF_W-1:0] offset
);

   localparam int STEP_W = $clog2(NUM_W);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [DVS_W-1:0]  rem_ff;
   logic [DVS_W-1:0]  dvs_ff;
   logic [OFF_W-1:0]  q_ff;
   logic              ovf_ff;
   logic              neg_ff;
   logic [OFF_W-1:0]  offset_ff;

   logic [DVS_W+1:0]  trial;
   logic              ge;
   logic [OFF_W-1:0]  q_in;
   logic              ovf_in;
   logic              pos_big;
   logic              neg_big;
   logic [OFF_W-1:0]  sat_in;

   assign trial   = {1'b0, rem_ff, num_ff[NUM_W-1]} - {2'b00, dvs_ff};
   assign ge      = ~trial[DVS_W+1];
   assign q_in    = {q_ff[OFF_W-2:0], ge};
   assign ovf_in  = ovf_ff | q_ff[OFF_W-1];
   assign pos_big = ovf_in | q_in[OFF_W-1];
   assign neg_big = ovf_in | (q_in[OFF_W-1] & (|q_in[OFF_W-2:0]));

   always_comb begin
      if (neg_ff) begin
         sat_in = neg_big ? OFF_MIN : (~q_in + OFF_W'(1));
      end else begin
         sat_in = pos_big ? OFF_MAX : q_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            num_ff  <= num;
            dvs_ff  <= dvs;
            neg_ff  <= neg;
            rem_ff  <= '0;
            q_ff    <= '0;
            ovf_ff  <= 1'b0;
         end else if (busy_ff) begin
            num_ff <= {num_ff[NUM_W-2:0], 1'b0};
            rem_ff <= ge ? trial[DVS_W-1:0] : {rem_ff[DVS_W-2:0], num_ff[NUM_W-1]};
            q_ff   <= q_in;
            ovf_ff <= ovf_in;
            cnt_ff <= cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(NUM_W-1)) begin
               busy_ff   <= 1'b0;
               done_ff   <= 1'b1;
               offset_ff <= sat_in;
            end
         end
      end
   end

   assign done   = done_ff;
   assign offset = offset_ff;

endmodule

// ===== design/fmpl_mul.sv =====
// ----------------------------------------------------------------------------
// fmpl_mul
// Shift-add serial multiplier: one multiplier bit per cycle against the
// bin width.
// ----------------------------------------------------------------------------
module fmpl_mul import fmpl_pkg::*; #(
   parameter int MUL_W = 17
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [CFG_W-1:0]       mcand,
   input  logic [MUL_W-1:0]       mplier,
   output logic                   done,
   output logic [CFG_W+MUL_W-1:0] product
);

   localparam int STEP_W = $clog2(MUL_W);

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [CFG_W-1:0]  mc_ff;
   logic [CFG_W-1:0]  hi_ff;
   logic [MUL_W-1:0]  lo_ff;
   logic [CFG_W:0]    sum;

   assign sum = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mc_ff} : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            mc_ff   <= mcand;
            hi_ff   <= '0;
            lo_ff   <= mplier;
         end else if (busy_ff) begin
            hi_ff  <= sum[CFG_W:1];
            lo_ff  <= {sum[0], lo_ff[MUL_W-1:1]};
            cnt_ff <= cnt_ff + STEP_W'(1);
            if (cnt_ff == STEP_W'(MUL_W-1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

// ===== design/first_minimum_parabolic_locator.sv =====
// ----------------------------------------------------------------------------
// first_minimum_parabolic_locator
// Streams histogram bins, finds the first local minimum below 1.0 and
// reports its parabolic vertex position once per frame.
// ----------------------------------------------------------------------------
// Bins are taken one per cycle while the request side is not held. The bin that
// confirms a minimum with a nonzero denominator holds it while the serial divider
// produces one quotient bit per cycle. The last bin of a frame that has a minimum
// holds it while the shift-add multiplier (MUL_W = max(17, clog2(MAX_BINS+1)))
// runs once for the bin center and once for the offset; a frame without a
// minimum holds it only to emit. A finished result sits in an output register,
// so the next frame streams in while it waits.
module first_minimum_parabolic_locator import fmpl_pkg::*; #(
   parameter int MAX_BINS = 1024
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [VALUE_W-1:0]      req_bin_value,
   input  logic                    req_frame_end,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [STATUS_W-1:0]     rsp_status,
   output logic [MIN_BIN_W-1:0]    rsp_min_bin,
   output logic signed [OFF_W-1:0] rsp_offset_bins,
   output logic signed [POS_W-1:0] rsp_position,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready
);

   localparam int CNT_W  = $clog2(MAX_BINS + 1);
   localparam int MUL_W  = (CNT_W > OFF_W) ? CNT_W : OFF_W;
   localparam int PROD_W = CFG_W + MUL_W;
   localparam int TERM_W = PROD_W + 1 - FRAC_W;
   localparam int SUM_W  = PROD_W + 2;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_DIV,
      ST_MUL_BASE,
      ST_MUL_OFF,
      ST_SUM,
      ST_EMIT
   } state_type;

   cfg_type cfg;

   state_type            state_ff;
   logic [VALUE_W-1:0]   win_ff [3];
   logic [CNT_W-1:0]     count_ff;
   logic                 found_ff;
   logic                 flat_ff;
   logic [CNT_W-1:0]     found_bin_ff;
   logic [OFF_W-1:0]     found_off_ff;
   logic                 end_pend_ff;
   logic                 mul_go_ff;
   logic [PROD_W:0]      base_ff;
   logic [SUM_W-1:0]     term_ff;
   logic [POS_W-1:0]     pos_ff;
   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  status_ff;
   logic [MIN_BIN_W-1:0] min_bin_ff;
   logic [OFF_W-1:0]     offset_ff;
   logic [POS_W-1:0]     position_ff;

   logic                 accept;
   logic                 in_range;
   logic [DEN_W-1:0]     den_s;
   logic                 den_zero;
   logic [DEN_W-1:0]     den_abs;
   logic [OFF_W-1:0]     diff_s;
   logic [OFF_W-1:0]     diff_abs;
   logic [NUM_W-1:0]     div_num;
   logic [DVS_W-1:0]     div_dvs;
   logic                 div_neg;
   logic                 det;
   logic                 div_start;
   logic                 div_done;
   logic [OFF_W-1:0]     div_offset;

   logic [CNT_W-1:0]     fb_m1;
   logic [OFF_W-1:0]     off_abs;
   logic [MUL_W-1:0]     mul_b;
   logic                 mul_done;
   logic [PROD_W-1:0]    product;
   logic [PROD_W:0]      rnd_sum;
   logic [TERM_W-1:0]    term_mag;
   logic [SUM_W-1:0]     term_ext;
   logic [SUM_W-1:0]     pos_full;
   logic [SUM_W-POS_W:0] pos_top;
   logic                 pos_fits;
   logic [POS_W-1:0]     pos_sat;
   logic [CNT_W+MIN_BIN_W-1:0] fb_ext;

   fmpl_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_ready = (state_ff == ST_RUN);
   assign accept    = req_valid & req_ready;
   assign in_range  = (count_ff < CNT_W'(MAX_BINS));

   // window: [0] next, [1] current, [2] previous
   assign den_s    = {2'b00, win_ff[1], 1'b0} - {3'b000, win_ff[0]} - {3'b000, win_ff[2]};
   assign den_zero = (den_s == '0);
   assign den_abs  = den_s[DEN_W-1] ? (~den_s + DEN_W'(1)) : den_s;
   assign diff_s   = {1'b0, win_ff[0]} - {1'b0, win_ff[2]};
   assign diff_abs = diff_s[OFF_W-1] ? (~diff_s + OFF_W'(1)) : diff_s;
   assign div_num  = {1'b0, diff_abs[VALUE_W-1:0], {FRAC_W{1'b0}}}
                   + {{(NUM_W-DVS_W+1){1'b0}}, den_abs[DVS_W-2:0]};
   assign div_dvs  = {den_abs[DVS_W-2:0], 1'b0};
   assign div_neg  = diff_s[OFF_W-1] ^ den_s[DEN_W-1];

   assign det = in_range & ~found_ff & (count_ff >= CNT_W'(3))
              & (win_ff[0] > win_ff[1]) & (req_bin_value > win_ff[1])
              & (win_ff[1] < ONE_Q14);
   assign div_start = accept & det & ~den_zero;

   fmpl_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .dvs    (div_dvs),
      .neg    (div_neg),
      .done   (div_done),
      .offset (div_offset)
   );

   assign fb_m1   = found_bin_ff - CNT_W'(1);
   assign off_abs = found_off_ff[OFF_W-1] ? (~found_off_ff + OFF_W'(1)) : found_off_ff;
   assign mul_b   = (state_ff == ST_MUL_BASE) ? MUL_W'(fb_m1) : MUL_W'(off_abs);

   fmpl_mul #(
      .MUL_W (MUL_W)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_go_ff),
      .mcand   (cfg.bin_width),
      .mplier  (mul_b),
      .done    (mul_done),
      .product (product)
   );

   assign rnd_sum  = {1'b0, product} + (PROD_W+1)'(ROUND_HALF);
   assign term_mag = rnd_sum[PROD_W:FRAC_W];
   assign term_ext = SUM_W'(term_mag);
   assign pos_full = {1'b0, base_ff} + term_ff;
   assign pos_top  = pos_full[SUM_W-1:POS_W-1];
   assign pos_fits = (&pos_top) | ~(|pos_top);
   assign pos_sat  = pos_fits ? pos_full[POS_W-1:0]
                   : (pos_full[SUM_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                        : {1'b0, {(POS_W-1){1'b1}}});
   assign fb_ext   = {{MIN_BIN_W{1'b0}}, found_bin_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         win_ff[0]    <= '0;
         win_ff[1]    <= '0;
         win_ff[2]    <= '0;
         count_ff     <= '0;
         found_ff     <= 1'b0;
         flat_ff      <= 1'b0;
         found_bin_ff <= '0;
         found_off_ff <= '0;
         end_pend_ff  <= 1'b0;
         mul_go_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_go_ff <= 1'b0;
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_RUN: begin
               if (accept) begin
                  if (in_range) begin
                     win_ff[2] <= win_ff[1];
                     win_ff[1] <= win_ff[0];
                     win_ff[0] <= req_bin_value;
                     count_ff  <= count_ff + CNT_W'(1);
                     if (det) begin
                        found_ff     <= 1'b1;
                        found_bin_ff <= count_ff - CNT_W'(1);
                        flat_ff      <= den_zero;
                     end
                  end
                  end_pend_ff <= req_frame_end;
                  if (div_start) begin
                     state_ff <= ST_DIV;
                  end else if (req_frame_end) begin
                     if (found_ff || det) begin
                        state_ff  <= ST_MUL_BASE;
                        mul_go_ff <= 1'b1;
                     end else begin
                        state_ff <= ST_EMIT;
                     end
                  end
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  found_off_ff <= div_offset;
                  if (end_pend_ff) begin
                     state_ff  <= ST_MUL_BASE;
                     mul_go_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_RUN;
                  end
               end
            end
            ST_MUL_BASE: begin
               if (mul_done) begin
                  base_ff   <= {1'b0, product} + (PROD_W+1)'(cfg.first_bin_center);
                  state_ff  <= ST_MUL_OFF;
                  mul_go_ff <= 1'b1;
               end
            end
            ST_MUL_OFF: begin
               if (mul_done) begin
                  term_ff  <= found_off_ff[OFF_W-1] ? (~term_ext + SUM_W'(1)) : term_ext;
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               pos_ff   <= pos_sat;
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff <= 1'b1;
                  if (found_ff) begin
                     status_ff   <= flat_ff ? STATUS_FLAT : STATUS_FOUND;
                     min_bin_ff  <= fb_ext[MIN_BIN_W-1:0];
                     offset_ff   <= found_off_ff;
                     position_ff <= pos_ff;
                  end else begin
                     status_ff   <= STATUS_NONE;
                     min_bin_ff  <= '0;
                     offset_ff   <= '0;
                     position_ff <= '0;
                  end
                  win_ff[0]    <= '0;
                  win_ff[1]    <= '0;
                  win_ff[2]    <= '0;
                  count_ff     <= '0;
                  found_ff     <= 1'b0;
                  flat_ff      <= 1'b0;
                  found_bin_ff <= '0;
                  found_off_ff <= '0;
                  state_ff     <= ST_RUN;
               end
            end
            default: state_ff <= ST_RUN;
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_min_bin     = min_bin_ff;
   assign rsp_offset_bins = offset_ff;
   assign rsp_position    = position_ff;

endmodule

// ===== dv/first_minimum_parabolic_locator_tb.sv =====
// ----------------------------------------------------------------------------
// first_minimum_parabolic_locator_tb
// Streams histogram frames into the locator through its request channel and
// checks every per-frame report against an in-bench model of the minimum
// search, the parabolic vertex and the position arithmetic. Register settings
// change between phases, both handshake sides idle at random, and one long
// receiver hold-off backs the block up into its request side.
// ----------------------------------------------------------------------------
module first_minimum_parabolic_locator_tb import fmpl_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int     MAX_BINS     = 1024;
   localparam longint UNITY        = longint'(1) << FRAC_W;
   localparam longint OFF_HI       = (longint'(1) << (OFF_W - 1)) - 1;
   localparam longint OFF_LO       = -(longint'(1) << (OFF_W - 1));
   localparam longint POS_HI       = (longint'(1) << (POS_W - 1)) - 1;
   localparam longint POS_LO       = -(longint'(1) << (POS_W - 1));
   localparam int     DRAIN_CYCLES = 120;
   localparam int     HOLD_CYCLES  = 700;
   localparam int     CYCLE_LIMIT  = 600000;
   localparam int     NUM_PHASES   = 5;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [MIN_BIN_W-1:0]    min_bin;
      logic signed [OFF_W-1:0] offset_bins;
      logic signed [POS_W-1:0] position;
   } frame_report_type;

   class minimum_tracker_type;
      logic [CFG_W-1:0]   center;
      logic [CFG_W-1:0]   width;
      logic [VALUE_W-1:0] window [3];
      int unsigned        bin_count;
      bit                 found;
      int unsigned        found_bin;
      longint             found_offset;
      bit                 flat;
      frame_report_type   pending_reports [$];
      int                 mismatches;
      int                 reports_checked;
      int                 n_found;
      int                 n_flat;
      int                 n_none;
      int                 n_offset_sat;
      int                 n_position_sat;

      function new();
         center = '0;
         width = BIN_WIDTH_RST;
         mismatches = 0;
         reports_checked = 0;
         n_found = 0;
         n_flat = 0;
         n_none = 0;
         n_offset_sat = 0;
         n_position_sat = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         window[0] = '0;
         window[1] = '0;
         window[2] = '0;
         bin_count = 0;
         found = 1'b0;
         found_bin = 0;
         found_offset = 0;
         flat = 1'b0;
      endfunction

      function void set_register(logic idx, logic [CFG_W-1:0] value);
         if (idx == CSR_FIRST_BIN_CENTER) center = value;
         else width = value;
      endfunction

      function void complain(string what);
         mismatches++;
         if (mismatches <= 10) $display("[%0t] MISMATCH %s", $realtime, what);
      endfunction

      // nearest, ties away from zero
      function longint round_div(longint a, longint b);
         bit     neg;
         longint ma;
         longint mb;
         longint q;
         neg = (a < 0) != (b < 0);
         ma = (a < 0) ? -a : a;
         mb = (b < 0) ? -b : b;
         q = (ma + mb / 2) / mb;
         return neg ? -q : q;
      endfunction

      function void look_for_minimum(logic [VALUE_W-1:0] newest_value, int unsigned k);
         longint prev;
         longint cur;
         longint nxt;
         longint newest;
         longint den;
         longint q;
         if (found || k < 4) return;
         prev = window[2];
         cur = window[1];
         nxt = window[0];
         newest = newest_value;
         if (!(nxt > cur && newest > cur && cur < UNITY)) return;
         found = 1'b1;
         found_bin = k - 2;
         den = 2 * cur - nxt - prev;
         if (den == 0) begin
            flat = 1'b1;
            found_offset = 0;
            return;
         end
         q = round_div((nxt - prev) * UNITY, 2 * den);
         if (q > OFF_HI || q < OFF_LO) n_offset_sat++;
         if (q > OFF_HI) q = OFF_HI;
         if (q < OFF_LO) q = OFF_LO;
         found_offset = q;
      endfunction

      function frame_report_type summarize();
         frame_report_type r;
         longint           pos;
         longint           c;
         longint           w;
         r = '0;
         r.status = STATUS_NONE;
         if (!found) begin
            n_none++;
            return r;
         end
         c = center;
         w = width;
         pos = c + (longint'(found_bin) - 1) * w;
         if (!flat) pos += round_div(w * found_offset, UNITY);
         if (pos > POS_HI || pos < POS_LO) n_position_sat++;
         if (pos > POS_HI) pos = POS_HI;
         if (pos < POS_LO) pos = POS_LO;
         if (flat) n_flat++;
         else n_found++;
         r.status = flat ? STATUS_FLAT : STATUS_FOUND;
         r.min_bin = MIN_BIN_W'(found_bin);
         r.offset_bins = OFF_W'(found_offset);
         r.position = POS_W'(pos);
         return r;
      endfunction

      function void take_bin(logic [VALUE_W-1:0] value, logic last);
         int unsigned k;
         if (bin_count < MAX_BINS) begin
            k = bin_count + 1;
            look_for_minimum(value, k);
            window[2] = window[1];
            window[1] = window[0];
            window[0] = value;
            bin_count = k;
         end
         if (last) begin
            pending_reports.push_back(summarize());
            clear_frame();
         end
      endfunction

      function void match_report(logic [STATUS_W-1:0] status, logic [MIN_BIN_W-1:0] min_bin,
                                 logic signed [OFF_W-1:0] offset_bins,
                                 logic signed [POS_W-1:0] position);
         frame_report_type e;
         if (pending_reports.size() == 0) begin
            complain($sformatf("report with no frame pending: status %0d bin %0d",
                               status, min_bin));
            return;
         end
         e = pending_reports.pop_front();
         reports_checked++;
         if (e.status !== status || e.min_bin !== min_bin ||
             e.offset_bins !== offset_bins || e.position !== position)
            complain($sformatf({"report %0d: expected status %0d bin %0d offset %0d pos %0d,",
                                " got status %0d bin %0d offset %0d pos %0d"},
                               reports_checked, e.status, e.min_bin, e.offset_bins,
                               e.position, status, min_bin, offset_bins, position));
      endfunction

      function int pending_count();
         return pending_reports.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [VALUE_W-1:0]      req_bin_value;
   logic                    req_frame_end;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic [MIN_BIN_W-1:0]    rsp_min_bin;
   logic signed [OFF_W-1:0] rsp_offset_bins;
   logic signed [POS_W-1:0] rsp_position;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CSR_ADDR_W-1:0]   paddr;
   logic [CSR_DATA_W-1:0]   pwdata;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   minimum_tracker_type tracker = new();
   logic [VALUE_W-1:0]  frame_bins [$];
   int                  cycles = 0;
   int                  burst_left = 0;
   int                  bins_sent = 0;
   int                  frames_sent = 0;
   int                  longest_frame = 0;
   int                  settings_used = 0;
   bit                  long_hold_due = 1'b0;
   bit                  long_hold_done = 1'b0;
   int                  hold_left = 0;
   int                  stall_mode = 0;
   int                  mode_left = 0;

   first_minimum_parabolic_locator #(.MAX_BINS(MAX_BINS)) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_bin_value   (req_bin_value),
      .req_frame_end   (req_frame_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_min_bin     (rsp_min_bin),
      .rsp_offset_bins (rsp_offset_bins),
      .rsp_position    (rsp_position),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d reports outstanding", cycles,
                  tracker.pending_count());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: check, then pick next ready from the stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         tracker.match_report(rsp_status, rsp_min_bin, rsp_offset_bins, rsp_position);
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (long_hold_due && !long_hold_done) begin
         long_hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(30, 300);
         end else begin
            mode_left = mode_left - 1;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 9) < 7);
            2: rsp_ready <= ($urandom_range(0, 9) < 3);
            default: rsp_ready <= (cycles % 5 != 0);
         endcase
      end
   end

   function automatic logic [VALUE_W-1:0] clip_bin(int v);
      if (v < 0) return '0;
      if (v > 65535) return '1;
      return VALUE_W'(v);
   endfunction

   function automatic void fill_random_frame();
      int kind;
      int len;
      int m;
      int lvl;
      int d;
      int e;
      int a;
      int span;
      int v;
      frame_bins.delete();
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         len = $urandom_range(1, 12);
         repeat (len) frame_bins.push_back(VALUE_W'($urandom));
      end else if (kind < 18) begin
         len = $urandom_range(1, 4);
         repeat (len) frame_bins.push_back(clip_bin($urandom_range(0, 40000)));
      end else if (kind < 70) begin
         len = $urandom_range(4, 24);
         m = $urandom_range(2, len - 2);
         lvl = $urandom_range(0, 24000);
         for (int i = 1; i <= len; i++) begin
            span = (i > m) ? i - m : m - i;
            v = lvl + span * $urandom_range(0, 2500);
            if ($urandom_range(0, 3) == 0) v = v - $urandom_range(0, 800);
            frame_bins.push_back(clip_bin(v));
         end
      end else if (kind < 82) begin
         len = $urandom_range(4, 10);
         a = $urandom_range(0, 16000);
         d = $urandom_range(0, 3000);
         for (int i = 0; i < len; i++) frame_bins.push_back(clip_bin(a + d * i));
      end else begin
         len = $urandom_range(4, 12);
         a = $urandom_range(0, 12000);
         d = $urandom_range(1, 2000);
         e = $urandom_range(0, 6) - 3;
         frame_bins.push_back(clip_bin(a));
         frame_bins.push_back(clip_bin(a + d));
         frame_bins.push_back(clip_bin(a + 2 * d + e));
         frame_bins.push_back(clip_bin(a + 3 * d + $urandom_range(0, 2000)));
         repeat (len - 4) frame_bins.push_back(VALUE_W'($urandom));
      end
   endfunction

   // minimum right at the last searchable bin, then bins past the limit
   function automatic void fill_long_frame();
      int lvl;
      frame_bins.delete();
      repeat (MAX_BINS - 4) frame_bins.push_back(clip_bin($urandom_range(40000, 65535)));
      lvl = $urandom_range(0, 1000);
      frame_bins.push_back(16'd60000);
      frame_bins.push_back(clip_bin(lvl));
      frame_bins.push_back(clip_bin(lvl + $urandom_range(1, 3000)));
      frame_bins.push_back(clip_bin(lvl + $urandom_range(1, 3000)));
      repeat ($urandom_range(1, 8)) frame_bins.push_back(clip_bin($urandom_range(0, 1) * 50000));
   endfunction

   task automatic send_bin(input logic [VALUE_W-1:0] value, input logic last);
      req_valid <= 1'b1;
      req_bin_value <= value;
      req_frame_end <= last;
      do @(posedge clock); while (!req_ready);
      tracker.take_bin(value, last);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 30)) @(posedge clock);
         else repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(0, 30);
      end
   endtask

   task automatic send_frame(inout int counted);
      for (int i = 0; i < frame_bins.size(); i++) begin
         send_bin(frame_bins[i], i == frame_bins.size() - 1);
         if (i < MAX_BINS) counted++;
      end
      frames_sent++;
      bins_sent += frame_bins.size();
      if (frame_bins.size() > longest_frame) longest_frame = frame_bins.size();
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (tracker.pending_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CFG_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      tracker.set_register(idx, value);
      @(posedge clock);
   endtask

   task automatic csr_check(input logic idx, input logic [CFG_W-1:0] want);
      logic [CSR_DATA_W-1:0] got;
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      got = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      if (got[CFG_W-1:0] !== want)
         tracker.complain($sformatf("register %0d read %0h, expected %0h", idx, got, want));
      @(posedge clock);
   endtask

   task automatic directed_frame(input logic [VALUE_W-1:0] values [$]);
      int unused;
      unused = 0;
      frame_bins = values;
      send_frame(unused);
   endtask

   initial begin
      logic [CFG_W-1:0] fbc;
      logic [CFG_W-1:0] bw;
      int               target;
      int               counted;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_bin_value <= '0;
      req_frame_end <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      csr_check(CSR_FIRST_BIN_CENTER, '0);
      csr_check(CSR_BIN_WIDTH, BIN_WIDTH_RST);
      settings_used++;

      // short frames, extremes, both offset clamps, a 1.0 reject and a just-below-1.0 find
      directed_frame('{16'd0});
      directed_frame('{16'd30000, 16'd100, 16'd30000});
      directed_frame('{16'd65535, 16'd0, 16'd40000, 16'd50000});
      directed_frame('{16'd100, 16'd200, 16'd300, 16'd400});
      directed_frame('{16'd0, 16'd1001, 16'd2001, 16'd3000});
      directed_frame('{16'd0, 16'd1000, 16'd2001, 16'd3000});
      directed_frame('{16'd40000, 16'd16384, 16'd20000, 16'd20000});
      directed_frame('{16'd20000, 16'd16383, 16'd16384, 16'd65535});
      settle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin fbc = '0; bw = '0; target = 150; end
            1: begin fbc = '1; bw = '1; target = 120; end
            2: begin fbc = CFG_W'($urandom); bw = CFG_W'($urandom); target = 200; end
            3: begin fbc = '0; bw = BIN_WIDTH_RST; target = 150; end
            default: begin
               fbc = CFG_W'($urandom_range(0, 4000000));
               bw = CFG_W'($urandom_range(1, 200000));
               target = 260;
            end
         endcase
         csr_write(CSR_FIRST_BIN_CENTER, fbc);
         csr_write(CSR_BIN_WIDTH, bw);
         csr_check(CSR_FIRST_BIN_CENTER, fbc);
         csr_check(CSR_BIN_WIDTH, bw);
         settings_used++;
         counted = 0;
         if (p == 1) begin
            fill_long_frame();
            send_frame(counted);
            counted = 0;
         end
         if (p == NUM_PHASES - 1) long_hold_due = 1'b1;
         while (counted < target) begin
            fill_random_frame();
            send_frame(counted);
         end
         settle();
      end

      if (tracker.pending_count() != 0)
         tracker.complain($sformatf("%0d reports never arrived", tracker.pending_count()));
      $display("covered %0d frames, %0d bins (longest %0d), %0d register settings",
               frames_sent, bins_sent, longest_frame, settings_used);
      $display("reports: %0d fitted, %0d flat, %0d empty; clamps: %0d offset, %0d position",
               tracker.n_found, tracker.n_flat, tracker.n_none, tracker.n_offset_sat,
               tracker.n_position_sat);
      if (tracker.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches", tracker.mismatches);
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
